### src/hdwt_pkg.sv
// Shared types and constants for the multi-level Haar wavelet transform block.
`default_nettype none

package hdwt_pkg;

   localparam int DATA_W     = 32;
   localparam int SUM_W      = DATA_W + 1;
   localparam int COEF_W     = 18;
   localparam int PROD_W     = SUM_W + COEF_W + 1;
   localparam int ROUND_SHIFT = 18;
   localparam int LG_W       = 3;
   localparam int INDEX_W    = 6;
   localparam int CSR_IDX_W  = 2;

   localparam logic [COEF_W-1:0] INV_SQRT2_Q18 = COEF_W'(185364);
   localparam logic [PROD_W-1:0] ROUND_HALF    = PROD_W'(131072);

   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_MODE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LOG2_LENGTH  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT  = CSR_IDX_W'(2);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RDA,
      S_RDB,
      S_SUM,
      S_MUL,
      S_WRA,
      S_WRB,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

### src/hdwt_scale_unit.sv
// Shared butterfly scaler: registered multiply by 1/sqrt2, round half up, saturate.
`default_nettype none

module hdwt_scale_unit (
   input  wire logic                               clock,
   input  wire logic signed [hdwt_pkg::SUM_W-1:0]  op_value,
   output logic signed [hdwt_pkg::DATA_W-1:0]      scaled_value
);
   import hdwt_pkg::*;

   localparam int Q_W = PROD_W - ROUND_SHIFT;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] rounded;
   logic signed [Q_W-1:0]    quot;

   localparam logic signed [Q_W-1:0] MAX_Q = Q_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
   localparam logic signed [Q_W-1:0] MIN_Q = -MAX_Q - Q_W'(1);

   assign prod_in = PROD_W'(op_value) * PROD_W'(signed'({1'b0, INV_SQRT2_Q18}));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      rounded = prod_ff + signed'(ROUND_HALF);
      quot    = Q_W'(rounded >>> ROUND_SHIFT);
      if (quot > MAX_Q) begin
         scaled_value = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (quot < MIN_Q) begin
         scaled_value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         scaled_value = quot[DATA_W-1:0];
      end
   end

endmodule

`default_nettype wire

### src/haar_dwt_in_place.sv
// Block-based in-place multi-level Haar wavelet transform with one shared butterfly scaler.
// Load: one sample per cycle while busy is low; N = 2^log2_length samples form a block.
// Transform: butterflies run RDA, RDB, SUM, MUL, WRA, WRB on one memory and one multiplier;
//   B = sum over levels of N/2^(l+1) butterflies (63 for N = 64 with 6 levels).
// Emit: N results on consecutive cycles once the last butterfly has been written.
// A new block cannot load until this one is transformed and emitted; results cannot stall.
// Reset: registers to 1/6/6, load count cleared, store contents undefined until loaded.
`default_nettype none

module haar_dwt_in_place #(
   parameter int MAX_LEN = 64
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic signed [hdwt_pkg::DATA_W-1:0]       req_sample_value,
   output logic                                          rsp_strobe,
   output logic signed [hdwt_pkg::DATA_W-1:0]            rsp_coeff_value,
   output logic        [hdwt_pkg::INDEX_W-1:0]           rsp_coeff_index,
   output logic                                          rsp_last_of_block,
   input  wire logic                                     csr_wr_en,
   input  wire logic   [hdwt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic   [hdwt_pkg::LG_W-1:0]              csr_wdata
);
   import hdwt_pkg::*;

   localparam int AW  = $clog2(MAX_LEN);
   localparam int LCW = $clog2(MAX_LEN + 1);
   localparam logic [LG_W-1:0] CAP = LG_W'($clog2(MAX_LEN + 1) - 1);

   state_type state_ff, state_in;

   logic            fwd_ff;
   logic [LG_W-1:0] lg_ff;
   logic [LG_W-1:0] lv_ff;

   logic [LG_W-1:0] lg_eff;
   logic [LG_W-1:0] lv_eff;
   logic [LCW-1:0]  len_cfg;
   logic [LCW-1:0]  count_inc;

   logic [LCW-1:0]  load_count_ff, load_count_in;
   logic            mode_ff, mode_in;
   logic [LG_W-1:0] lgb_ff, lgb_in;
   logic [LG_W-1:0] lvtop_ff, lvtop_in;
   logic [LG_W-1:0] lvl_ff, lvl_in;
   logic [LCW-1:0]  i_ff, i_in;
   logic [LCW-1:0]  e_ff, e_in;
   logic [LCW-1:0]  len_blk;
   logic [LCW-1:0]  skip;
   logic [LCW-1:0]  i_next;
   logic            pass_last;

   logic signed [DATA_W-1:0] a_ff, a_in;
   logic signed [DATA_W-1:0] b_ff, b_in;
   logic signed [SUM_W-1:0]  op_ff, op_in;
   logic signed [DATA_W-1:0] scaled;

   logic            strobe_ff, strobe_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic            last_ff, last_in;

   logic [DATA_W-1:0] mem [MAX_LEN];
   logic [DATA_W-1:0] rdata_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;

   hdwt_scale_unit u_scale (
      .clock        (clock),
      .op_value     (op_ff),
      .scaled_value (scaled)
   );

   always_comb begin
      lg_eff = lg_ff;
      if (lg_eff == '0) begin
         lg_eff = LG_W'(1);
      end
      if (lg_eff > CAP) begin
         lg_eff = CAP;
      end
      lv_eff = lv_ff;
      if (lv_eff == '0) begin
         lv_eff = LG_W'(1);
      end
      if (lv_eff > lg_eff) begin
         lv_eff = lg_eff;
      end
   end

   assign len_cfg   = LCW'(1) << lg_eff;
   assign count_inc = load_count_ff + LCW'(1);
   assign len_blk   = LCW'(1) << lgb_ff;
   assign skip      = LCW'(1) << lvl_ff;
   assign i_next    = i_ff + (skip << 1);
   assign pass_last = mode_ff ? (lvl_ff == lvtop_ff - LG_W'(1)) : (lvl_ff == '0);

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      mode_in       = mode_ff;
      lgb_in        = lgb_ff;
      lvtop_in      = lvtop_ff;
      lvl_in        = lvl_ff;
      i_in          = i_ff;
      e_in          = e_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      op_in         = op_ff;
      strobe_in     = 1'b0;
      idx_in        = idx_ff;
      last_in       = last_ff;
      mem_we        = 1'b0;
      mem_waddr     = load_count_ff[AW-1:0];
      mem_wdata     = req_sample_value;
      mem_raddr     = i_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mem_we = 1'b1;
               if (count_inc >= len_cfg) begin
                  load_count_in = '0;
                  mode_in       = fwd_ff;
                  lgb_in        = lg_eff;
                  lvtop_in      = lv_eff;
                  lvl_in        = fwd_ff ? '0 : lv_eff - LG_W'(1);
                  i_in          = '0;
                  state_in      = S_RDA;
               end else begin
                  load_count_in = count_inc;
               end
            end
         end
         S_RDA: begin
            mem_raddr = i_ff[AW-1:0];
            state_in  = S_RDB;
         end
         S_RDB: begin
            a_in      = rdata_ff;
            mem_raddr = AW'(i_ff + skip);
            state_in  = S_SUM;
         end
         S_SUM: begin
            b_in     = rdata_ff;
            op_in    = SUM_W'(a_ff) + SUM_W'(signed'(rdata_ff));
            state_in = S_MUL;
         end
         S_MUL: begin
            op_in    = SUM_W'(a_ff) - SUM_W'(b_ff);
            state_in = S_WRA;
         end
         S_WRA: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff[AW-1:0];
            mem_wdata = scaled;
            state_in  = S_WRB;
         end
         S_WRB: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(i_ff + skip);
            mem_wdata = scaled;
            state_in  = S_RDA;
            if (i_next >= len_blk) begin
               i_in = '0;
               if (pass_last) begin
                  e_in     = '0;
                  state_in = S_EMIT;
               end else begin
                  lvl_in = mode_ff ? lvl_ff + LG_W'(1) : lvl_ff - LG_W'(1);
               end
            end else begin
               i_in = i_next;
            end
         end
         S_EMIT: begin
            mem_raddr = e_ff[AW-1:0];
            strobe_in = 1'b1;
            idx_in    = e_ff[AW-1:0];
            last_in   = (e_ff + LCW'(1) == len_blk);
            e_in      = e_ff + LCW'(1);
            if (e_ff + LCW'(1) == len_blk) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         load_count_ff <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b1;
         lg_ff  <= LG_W'(6);
         lv_ff  <= LG_W'(6);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FORWARD_MODE: fwd_ff <= csr_wdata[0];
            CSR_LOG2_LENGTH:  lg_ff  <= csr_wdata;
            CSR_LEVEL_COUNT:  lv_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      lgb_ff   <= lgb_in;
      lvtop_ff <= lvtop_in;
      lvl_ff   <= lvl_in;
      i_ff     <= i_in;
      e_ff     <= e_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_coeff_value   = rdata_ff;
   assign rsp_coeff_index   = INDEX_W'(idx_ff);
   assign rsp_last_of_block = last_ff;

   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_EMIT))
      else $error("result strobe without an emit cycle");

   a_last_ends_block: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_of_block |=> !rsp_strobe)
      else $error("result transfer after final element of block");

   a_busy_mid_block: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_of_block |-> busy)
      else $error("block idle while results remain");

   a_load_count_range: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= LCW'(MAX_LEN))
      else $error("load count beyond store depth");

endmodule

`default_nettype wire

### tb/sv/haar_dwt_in_place_checker.sv
// Checker for the Haar wavelet block: tracks register writes, predicts coefficients, compares.
`default_nettype none

module haar_dwt_in_place_checker #(
   parameter int MAX_LEN = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic signed [hdwt_pkg::DATA_W-1:0]  req_sample_value,
   input  wire logic                                rsp_strobe,
   input  wire logic signed [hdwt_pkg::DATA_W-1:0]  rsp_coeff_value,
   input  wire logic        [hdwt_pkg::INDEX_W-1:0] rsp_coeff_index,
   input  wire logic                                rsp_last_of_block,
   input  wire logic                                csr_wr_en,
   input  wire logic        [hdwt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [hdwt_pkg::LG_W-1:0]    csr_wdata,
   output int                                       mismatch_count,
   output int                                       pending_results,
   output int                                       checked_count
);

   import hdwt_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic        [INDEX_W-1:0] index;
      logic                      last;
   } coeff_type;

   localparam int     DEPTH   = 1 << INDEX_W;
   localparam int     MAX_LG  = $clog2(MAX_LEN + 1) - 1;
   localparam longint SAT_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
   localparam longint SAT_MIN = -(longint'(1) <<< (DATA_W - 1));

   logic signed [DATA_W-1:0] block_words [DEPTH];
   logic                     mode_fwd;
   logic        [LG_W-1:0]   lg_reg;
   logic        [LG_W-1:0]   lv_reg;
   int unsigned              load_cnt;
   int                       eff_lg;
   int                       levels;
   int                       blk_len;
   int                       skip;
   int                       k;
   coeff_type                expected_coeffs[$];
   coeff_type                want;
   coeff_type                made;

   function automatic logic signed [DATA_W-1:0] scale_inv_root2(input longint s);
      longint q;
      q = (s * longint'(INV_SQRT2_Q18) + longint'(ROUND_HALF)) >>> ROUND_SHIFT;
      if (q > SAT_MAX) q = SAT_MAX;
      if (q < SAT_MIN) q = SAT_MIN;
      return DATA_W'(q);
   endfunction

   task automatic butterfly_pass(input int len, input int stride);
      int i;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      for (i = 0; i + stride < len; i += 2 * stride) begin
         a = block_words[i];
         b = block_words[i + stride];
         block_words[i]          = scale_inv_root2(longint'(a) + longint'(b));
         block_words[i + stride] = scale_inv_root2(longint'(a) - longint'(b));
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_cnt = 0;
         mode_fwd = 1'b1;
         lg_reg = LG_W'(6);
         lv_reg = LG_W'(6);
         expected_coeffs.delete();
         mismatch_count = 0;
         checked_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_coeffs.size() == 0) begin
               report_mismatch($sformatf("coefficient at index %0d with none expected",
                                         rsp_coeff_index));
            end else begin
               want = expected_coeffs.pop_front();
               checked_count++;
               if (rsp_coeff_value !== want.value)
                  report_mismatch($sformatf("index %0d value %h, expected %h",
                                            want.index, rsp_coeff_value, want.value));
               if (rsp_coeff_index !== want.index)
                  report_mismatch($sformatf("index %0d, expected %0d",
                                            rsp_coeff_index, want.index));
               if (rsp_last_of_block !== want.last)
                  report_mismatch($sformatf("index %0d last flag %b, expected %b",
                                            want.index, rsp_last_of_block, want.last));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FORWARD_MODE: mode_fwd = csr_wdata[0];
               CSR_LOG2_LENGTH:  lg_reg = csr_wdata;
               CSR_LEVEL_COUNT:  lv_reg = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            eff_lg = (lg_reg == 0) ? 1 : (lg_reg > MAX_LG) ? MAX_LG : int'(lg_reg);
            levels = (lv_reg == 0) ? 1 : int'(lv_reg);
            if (levels > eff_lg) levels = eff_lg;
            blk_len = 1 << eff_lg;
            if (load_cnt < DEPTH) block_words[load_cnt] = req_sample_value;
            load_cnt = (load_cnt + 1) % 128;
            if (load_cnt >= blk_len) begin
               load_cnt = 0;
               if (mode_fwd) begin
                  for (skip = 1; skip < (1 << levels); skip *= 2)
                     butterfly_pass(blk_len, skip);
               end else begin
                  for (skip = 1 << (levels - 1); skip > 0; skip /= 2)
                     butterfly_pass(blk_len, skip);
               end
               for (k = 0; k < blk_len; k++) begin
                  made.value = block_words[k];
                  made.index = INDEX_W'(k);
                  made.last  = (k == blk_len - 1);
                  expected_coeffs.push_back(made);
               end
            end
         end
      end
      pending_results <= expected_coeffs.size();
   end

endmodule

`default_nettype wire

### tb/sv/haar_dwt_in_place_tb.sv
// Testbench top for the Haar wavelet block: clock, reset, sample and register stimulus, verdict.
`default_nettype none

module haar_dwt_in_place_tb;

   import hdwt_pkg::*;

   localparam int MAX_LEN     = 64;
   localparam int MAX_LG      = $clog2(MAX_LEN);
   localparam int TOTAL_ITEMS = 400;

   localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic signed [DATA_W-1:0]    req_sample_value = '0;
   logic                        rsp_strobe;
   logic signed [DATA_W-1:0]    rsp_coeff_value;
   logic        [INDEX_W-1:0]   rsp_coeff_index;
   logic                        rsp_last_of_block;
   logic                        csr_wr_en = 1'b0;
   logic        [CSR_IDX_W-1:0] csr_index = CSR_FORWARD_MODE;
   logic        [LG_W-1:0]      csr_wdata = '0;

   int mismatch_count;
   int pending_results;
   int checked_count;

   int samples_sent  = 0;
   int fill          = 0;
   int cur_len       = MAX_LEN;
   int burst_left    = 0;
   int config_writes = 0;
   int phase         = 0;

   always #5 clock = ~clock;

   haar_dwt_in_place #(.MAX_LEN(MAX_LEN)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_sample_value  (req_sample_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_coeff_value   (rsp_coeff_value),
      .rsp_coeff_index   (rsp_coeff_index),
      .rsp_last_of_block (rsp_last_of_block),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   haar_dwt_in_place_checker #(.MAX_LEN(MAX_LEN)) coeff_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_sample_value  (req_sample_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_coeff_value   (rsp_coeff_value),
      .rsp_coeff_index   (rsp_coeff_index),
      .rsp_last_of_block (rsp_last_of_block),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .pending_results   (pending_results),
      .checked_count     (checked_count)
   );

   function automatic logic signed [DATA_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2, 3:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [LG_W-1:0] random_lg();
      if ($urandom_range(0, 3) == 0) return LG_W'($urandom_range(5, 7));
      return LG_W'($urandom_range(0, 4));
   endfunction

   task automatic push_sample(input logic signed [DATA_W-1:0] v);
      start <= 1'b1;
      req_sample_value <= v;
      do @(posedge clock); while (busy);
      samples_sent++;
      fill++;
      if (fill >= cur_len) fill = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // drop start and hold until every expected coefficient is out
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_regs(input logic [LG_W-1:0] mode_w, input logic [LG_W-1:0] lg_w,
                             input logic [LG_W-1:0] lv_w);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FORWARD_MODE;
      csr_wdata <= mode_w;
      @(posedge clock);
      csr_index <= CSR_LOG2_LENGTH;
      csr_wdata <= lg_w;
      @(posedge clock);
      csr_index <= CSR_LEVEL_COUNT;
      csr_wdata <= lv_w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_len = (lg_w == 0) ? 2 : (lg_w > MAX_LG) ? MAX_LEN : (1 << lg_w);
      config_writes++;
   endtask

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_regs(3'd1, 3'd1, 3'd1);
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);

      wait_idle();
      write_regs(3'd1, 3'd0, 3'd0);
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MAX);

      wait_idle();
      write_regs(3'd1, 3'd2, 3'd7);
      push_sample(32'sd0);
      push_sample(-32'sd1);
      push_sample(32'sd1);
      push_sample(32'sh8000_0001);

      wait_idle();
      write_regs(3'b110, 3'd2, 3'd2);
      push_sample(32'sh0001_0000);
      push_sample(-32'sh0001_0000);
      push_sample(SAMPLE_MAX);
      push_sample(32'sd1);

      // shrink the length partway through a block
      wait_idle();
      write_regs(3'd1, 3'd3, 3'd3);
      repeat (3) push_sample(random_sample());
      wait_idle();
      write_regs(3'd1, 3'd1, 3'd1);
      push_sample(random_sample());

      // grow the length partway through a block
      push_sample(random_sample());
      wait_idle();
      write_regs(3'd0, 3'd2, 3'd2);
      repeat (3) push_sample(random_sample());

      while (samples_sent < TOTAL_ITEMS) begin
         wait_idle();
         case (phase)
            0:       write_regs(3'd1, 3'd7, 3'd7);
            1:       write_regs(3'd0, 3'd6, 3'd6);
            default: write_regs(LG_W'($urandom_range(0, 7)), random_lg(),
                                LG_W'($urandom_range(0, 7)));
         endcase
         phase++;
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(1, cur_len - 1)) push_sample(random_sample());
               wait_idle();
               write_regs(LG_W'($urandom_range(0, 7)), random_lg(),
                          LG_W'($urandom_range(0, 7)));
            end
            do push_sample(random_sample()); while (fill != 0);
         end
      end

      wait_idle();
      repeat (16) @(posedge clock);
      $display("Covered %0d samples under %0d register settings, both directions, lengths 2..%0d.",
               samples_sent, config_writes, MAX_LEN);
      $display("Checked %0d coefficients, %0d mismatches.", checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
